// ===== src/fhs_pkg.sv =====
`default_nettype none
package fhs_pkg;

  // Frame layout constants
  localparam logic [7:0] SYNC_BYTE    = 8'h4B;
  localparam int unsigned HDR_BYTES   = 14;
  localparam int unsigned LAYOUT_BYTES = 35;

  // Byte positions in the full layout (every optional block present)
  localparam logic [5:0] POS_FRAG = 6'd14;
  localparam logic [5:0] POS_ACK  = 6'd18;
  localparam logic [5:0] POS_PRIO = 6'd26;
  localparam logic [5:0] POS_TS   = 6'd27;
  localparam logic [5:0] POS_END  = 6'd35;

  // Metadata sizes
  localparam logic [4:0] META_FRAG = 5'd4;
  localparam logic [4:0] META_ACK  = 5'd8;
  localparam logic [4:0] META_PRIO = 5'd1;
  localparam logic [4:0] META_TS   = 5'd8;

  // Flag bit positions
  localparam int unsigned FLAG_FRAG = 0;
  localparam int unsigned FLAG_ACK  = 1;
  localparam int unsigned FLAG_PRIO = 2;
  localparam int unsigned FLAG_TS   = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BUFFER_LIMIT = 2'd0;
  localparam logic [1:0] CFG_VERSION_BYTE = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_FRAME = 2'd2;

  // Input op codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_ERR
  } cmd_kind_t;

  // One classified item, handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic        last;
    logic [1:0]  status;
    logic [15:0] len;
    logic [7:0]  data;      // payload byte, or version byte on headers
    logic        plen_zero;
    logic [7:0]  chan;
    logic [7:0]  ftype;
    logic [15:0] flags;
    logic [63:0] pkt;
    logic [15:0] fidx;
    logic [15:0] fcnt;
    logic [63:0] ack;
    logic [7:0]  prio;
    logic [63:0] ts;
  } cmd_t;

  // One result byte
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [15:0] len;
  } res_t;

  // Next layout position, skipping absent metadata blocks
  function automatic logic [5:0] fhs_next_pos(input logic [5:0] pos, input logic [3:0] fl);
    logic [5:0] p;
    p = pos + 6'd1;
    if (p == POS_FRAG && !fl[FLAG_FRAG]) p = POS_ACK;
    if (p == POS_ACK  && !fl[FLAG_ACK])  p = POS_PRIO;
    if (p == POS_PRIO && !fl[FLAG_PRIO]) p = POS_TS;
    if (p == POS_TS   && !fl[FLAG_TS])   p = POS_END;
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== src/fhs_front.sv =====
`default_nettype none
module fhs_front
  import fhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item
  input  wire logic        acc,
  input  wire logic        op_code,
  input  wire logic [7:0]  channel_id,
  input  wire logic [7:0]  frame_type,
  input  wire logic [15:0] flag_word,
  input  wire logic [63:0] packet_number,
  input  wire logic [15:0] frag_pos,
  input  wire logic [15:0] fragment_count,
  input  wire logic [63:0] ack_number,
  input  wire logic [7:0]  priority_level,
  input  wire logic [63:0] time_stamp,
  input  wire logic [15:0] payload_length,
  input  wire logic [7:0]  payload_byte,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // classified command
  output cmd_t             cmd
);

  logic [15:0] limit_r;
  logic [7:0]  version_r;
  logic        open_r, open_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] curlen_r, curlen_nxt;

  logic [4:0]  meta;
  logic [16:0] total;
  logic        too_big;
  logic [15:0] left_dec;

  // Size the frame
  always_comb begin
    meta = 5'd0;
    if (flag_word[FLAG_FRAG]) meta = meta + META_FRAG;
    if (flag_word[FLAG_ACK])  meta = meta + META_ACK;
    if (flag_word[FLAG_PRIO]) meta = meta + META_PRIO;
    if (flag_word[FLAG_TS])   meta = meta + META_TS;
    total   = 17'(HDR_BYTES) + {12'd0, meta} + {1'b0, payload_length};
    too_big = total > {1'b0, limit_r};
  end

  assign left_dec = left_r - 16'd1;

  // Classify the item and work out the next frame state
  always_comb begin
    open_nxt   = open_r;
    left_nxt   = left_r;
    curlen_nxt = curlen_r;
    cmd           = '0;
    cmd.kind      = CMD_ERR;
    cmd.chan      = channel_id;
    cmd.ftype     = frame_type;
    cmd.flags     = flag_word;
    cmd.pkt       = packet_number;
    cmd.fidx      = frag_pos;
    cmd.fcnt      = fragment_count;
    cmd.ack       = ack_number;
    cmd.prio      = priority_level;
    cmd.ts        = time_stamp;
    cmd.plen_zero = (payload_length == 16'd0);
    if (op_code == OP_START) begin
      if (too_big) begin
        cmd.kind   = CMD_ERR;
        cmd.last   = 1'b1;
        cmd.status = ST_TOO_BIG;
        cmd.len    = total[16] ? 16'hFFFF : total[15:0];
        open_nxt   = 1'b0;
        left_nxt   = 16'd0;
        curlen_nxt = 16'd0;
      end else begin
        cmd.kind   = CMD_HDR;
        cmd.status = ST_OK;
        cmd.len    = total[15:0];
        cmd.data   = version_r;
        open_nxt   = (payload_length != 16'd0);
        left_nxt   = payload_length;
        curlen_nxt = total[15:0];
      end
    end else if (!open_r) begin
      cmd.kind   = CMD_ERR;
      cmd.last   = 1'b1;
      cmd.status = ST_NO_FRAME;
      cmd.len    = 16'd0;
    end else begin
      cmd.kind   = CMD_DATA;
      cmd.data   = payload_byte;
      cmd.last   = (left_dec == 16'd0);
      cmd.status = ST_OK;
      cmd.len    = curlen_r;
      left_nxt   = left_dec;
      open_nxt   = (left_dec != 16'd0);
    end
  end

  // Hold configuration and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= 16'hFFFF;
      version_r <= 8'd0;
      open_r    <= 1'b0;
      left_r    <= 16'd0;
      curlen_r  <= 16'd0;
    end else begin
      if (cfg_we && cfg_index == CFG_BUFFER_LIMIT) limit_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_VERSION_BYTE) version_r <= cfg_data[7:0];
      if (acc) begin
        open_r   <= open_nxt;
        left_r   <= left_nxt;
        curlen_r <= curlen_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/fhs_cmd_queue.sv =====
`default_nettype none
module fhs_cmd_queue
  import fhs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wr_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== src/fhs_back.sv =====
`default_nettype none
module fhs_back
  import fhs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  // command side
  input  wire logic cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  // result side
  output logic      res_empty,
  input  wire logic res_pop,
  output res_t      res
);

  logic [5:0] pos_r, pos_nxt;
  logic [0:LAYOUT_BYTES-1][7:0] lay;
  logic [5:0] next_pos;
  logic       hdr_end;
  logic       emit;
  res_t       emit_res;

  res_t       buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  // Lay out every header and metadata byte in send order
  assign lay = {SYNC_BYTE, cmd.data, cmd.chan, cmd.ftype, cmd.flags, cmd.pkt,
                cmd.fidx, cmd.fcnt, cmd.ack, cmd.prio, cmd.ts};

  assign next_pos = fhs_next_pos(pos_r, cmd.flags[3:0]);
  assign hdr_end  = (next_pos == POS_END);
  assign emit     = !cmd_empty && (cnt_r != 2'd2);

  // Build the result byte and decide when the command is done
  always_comb begin
    emit_res = '0;
    cmd_pop  = 1'b0;
    pos_nxt  = pos_r;
    unique case (cmd.kind)
      CMD_HDR: begin
        emit_res.data   = lay[pos_r];
        emit_res.last   = hdr_end && cmd.plen_zero;
        emit_res.status = ST_OK;
        emit_res.len    = cmd.len;
        if (emit) begin
          cmd_pop = hdr_end;
          pos_nxt = hdr_end ? 6'd0 : next_pos;
        end
      end
      CMD_DATA: begin
        emit_res.data   = cmd.data;
        emit_res.last   = cmd.last;
        emit_res.status = cmd.status;
        emit_res.len    = cmd.len;
        cmd_pop         = emit;
      end
      default: begin
        emit_res.data   = 8'd0;
        emit_res.last   = cmd.last;
        emit_res.status = cmd.status;
        emit_res.len    = cmd.len;
        cmd_pop         = emit;
      end
    endcase
  end

  // Hold the byte position within the header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 6'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Two-entry result buffer decouples the serializer from the consumer
  assign res_empty = (cnt_r == 2'd0);
  assign res       = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (emit) buf_r[wr_ptr_r] <= emit_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (emit) wr_ptr_r <= ~wr_ptr_r;
      if (res_pop && !res_empty) rd_ptr_r <= ~rd_ptr_r;
      if (emit && !(res_pop && !res_empty))      cnt_r <= cnt_r + 2'd1;
      else if (!emit && res_pop && !res_empty)   cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== src/frame_header_serializer_core.sv =====
`default_nettype none
// Channel   Transfer when                 Carries
// input     in_push & !in_full            start item (header fields) or payload byte
// result    out_pop & !out_empty          one frame byte with last, status, length
// config    cfg_valid & cfg_ready         cfg_index (0 buffer_limit, 1 version_byte)
//
// A payload or error item yields one byte; an accepted start item yields 14 to 35
// bytes, one per cycle from the serializer while the result buffer has room, so
// input is taken one item per cycle while the serializer keeps up. With both queues
// empty, the item enters the command queue, then its first result the result buffer.
// A two-entry command queue sits between classifier and serializer, and a
// two-entry result buffer sits after it; either side stalls on its own.
// Reset is synchronous, active low; cfg_ready is always high.
module frame_header_serializer_core
  import fhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_op_code,
  input  wire logic [7:0]  in_channel_id,
  input  wire logic [7:0]  in_frame_type,
  input  wire logic [15:0] in_flag_word,
  input  wire logic [63:0] in_packet_number,
  input  wire logic [15:0] in_frag_pos,
  input  wire logic [15:0] in_fragment_count,
  input  wire logic [63:0] in_ack_number,
  input  wire logic [7:0]  in_priority_level,
  input  wire logic [63:0] in_time_stamp,
  input  wire logic [15:0] in_payload_length,
  input  wire logic [7:0]  in_payload_byte,
  // result channel
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_byte,
  output logic             out_last_byte,
  output logic [1:0]       out_status_code,
  output logic [15:0]      out_frame_length,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic in_acc;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_empty;
  logic q_pop;
  res_t res;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_push && !in_full;

  fhs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .op_code       (in_op_code),
    .channel_id    (in_channel_id),
    .frame_type    (in_frame_type),
    .flag_word     (in_flag_word),
    .packet_number (in_packet_number),
    .frag_pos      (in_frag_pos),
    .fragment_count(in_fragment_count),
    .ack_number    (in_ack_number),
    .priority_level(in_priority_level),
    .time_stamp    (in_time_stamp),
    .payload_length(in_payload_length),
    .payload_byte  (in_payload_byte),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (front_cmd)
  );

  fhs_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .wr_cmd(front_cmd),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (head_cmd)
  );

  fhs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(q_empty),
    .cmd      (head_cmd),
    .cmd_pop  (q_pop),
    .res_empty(out_empty),
    .res_pop  (out_pop),
    .res      (res)
  );

  assign out_byte         = res.data;
  assign out_last_byte    = res.last;
  assign out_status_code  = res.status;
  assign out_frame_length = res.len;

endmodule
`default_nettype wire

// ===== bench/tb_frame_header_serializer_core.sv =====
`timescale 1ns / 1ps

module tb_frame_header_serializer_core;
  import fhs_pkg::*;

  // Field fill modes for start items
  localparam int FILL_ZERO = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_RAND = 2;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic        op;
    logic [7:0]  chan;
    logic [7:0]  ftype;
    logic [15:0] flags;
    logic [63:0] pkt;
    logic [15:0] fidx;
    logic [15:0] fcnt;
    logic [63:0] ack;
    logic [7:0]  prio;
    logic [63:0] ts;
    logic [15:0] plen;
    logic [7:0]  pbyte;
  } frame_item_t;

  // Frame byte predictor and in-order byte checker
  class frame_scoreboard;
    logic [15:0] limit_reg;
    logic [7:0]  version_reg;
    logic        frame_open;
    logic [15:0] bytes_left;
    logic [15:0] frame_len;
    res_t        byte_q[$];
    int          errors;

    function new();
      limit_reg   = 16'hFFFF;
      version_reg = 8'h00;
      frame_open  = 1'b0;
      bytes_left  = 16'h0000;
      frame_len   = 16'h0000;
      errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_BUFFER_LIMIT) begin
        limit_reg = val;
      end else if (idx == CFG_VERSION_BYTE) begin
        version_reg = val[7:0];
      end
    endfunction

    function int pending();
      return byte_q.size();
    endfunction

    function void queue_byte(logic [7:0] b, logic last, logic [1:0] st, logic [15:0] len);
      res_t r;
      r.data   = b;
      r.last   = last;
      r.status = st;
      r.len    = len;
      byte_q.push_back(r);
    endfunction

    // Emit a field most significant byte first
    function void queue_be(logic [63:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) begin
        queue_byte(v[i*8 +: 8], 1'b0, ST_OK, frame_len);
      end
    endfunction

    function void note_input(frame_item_t it);
      logic [16:0] total;
      logic [4:0]  meta;
      res_t        tail;
      if (it.op == OP_START) begin
        meta = '0;
        if (it.flags[FLAG_FRAG]) meta += META_FRAG;
        if (it.flags[FLAG_ACK])  meta += META_ACK;
        if (it.flags[FLAG_PRIO]) meta += META_PRIO;
        if (it.flags[FLAG_TS])   meta += META_TS;
        total = 17'(HDR_BYTES) + 17'(meta) + 17'(it.plen);
        if (total > 17'(limit_reg)) begin
          // Reject and close whatever frame was open
          frame_open = 1'b0;
          bytes_left = 16'h0000;
          frame_len  = 16'h0000;
          queue_byte(8'h00, 1'b1, ST_TOO_BIG, total[16] ? 16'hFFFF : total[15:0]);
        end else begin
          frame_len  = total[15:0];
          bytes_left = it.plen;
          frame_open = (it.plen != 16'h0000);
          queue_byte(SYNC_BYTE, 1'b0, ST_OK, frame_len);
          queue_byte(version_reg, 1'b0, ST_OK, frame_len);
          queue_byte(it.chan, 1'b0, ST_OK, frame_len);
          queue_byte(it.ftype, 1'b0, ST_OK, frame_len);
          queue_be(64'(it.flags), 2);
          queue_be(it.pkt, 8);
          if (it.flags[FLAG_FRAG]) begin
            queue_be(64'(it.fidx), 2);
            queue_be(64'(it.fcnt), 2);
          end
          if (it.flags[FLAG_ACK])  queue_be(it.ack, 8);
          if (it.flags[FLAG_PRIO]) queue_be(64'(it.prio), 1);
          if (it.flags[FLAG_TS])   queue_be(it.ts, 8);
          // No payload: the header itself closes the frame
          if (it.plen == 16'h0000) begin
            tail = byte_q.pop_back();
            tail.last = 1'b1;
            byte_q.push_back(tail);
          end
        end
      end else if (!frame_open) begin
        queue_byte(8'h00, 1'b1, ST_NO_FRAME, 16'h0000);
      end else begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'h0000) frame_open = 1'b0;
        queue_byte(it.pbyte, bytes_left == 16'h0000, ST_OK, frame_len);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      if (byte_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b status %0d len %0d",
                         got.data, got.last, got.status, got.len));
        return;
      end
      want = byte_q.pop_front();
      if (got.data !== want.data || got.last !== want.last ||
          got.status !== want.status || got.len !== want.len) begin
        report($sformatf("got byte %02h last %0b status %0d len %0d, want %02h %0b %0d %0d",
                         got.data, got.last, got.status, got.len,
                         want.data, want.last, want.status, want.len));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_push           = 1'b0;
  logic        in_full;
  logic        in_op_code        = 1'b0;
  logic [7:0]  in_channel_id     = '0;
  logic [7:0]  in_frame_type     = '0;
  logic [15:0] in_flag_word      = '0;
  logic [63:0] in_packet_number  = '0;
  logic [15:0] in_frag_pos       = '0;
  logic [15:0] in_fragment_count = '0;
  logic [63:0] in_ack_number     = '0;
  logic [7:0]  in_priority_level = '0;
  logic [63:0] in_time_stamp     = '0;
  logic [15:0] in_payload_length = '0;
  logic [7:0]  in_payload_byte   = '0;
  logic        out_empty;
  logic        out_pop           = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic [1:0]  out_status_code;
  logic [15:0] out_frame_length;
  logic        cfg_valid         = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index         = '0;
  logic [15:0] cfg_data          = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  frame_scoreboard sb = new();
  res_t            seen;

  frame_header_serializer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op_code        (in_op_code),
    .in_channel_id     (in_channel_id),
    .in_frame_type     (in_frame_type),
    .in_flag_word      (in_flag_word),
    .in_packet_number  (in_packet_number),
    .in_frag_pos       (in_frag_pos),
    .in_fragment_count (in_fragment_count),
    .in_ack_number     (in_ack_number),
    .in_priority_level (in_priority_level),
    .in_time_stamp     (in_time_stamp),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .out_status_code   (out_status_code),
    .out_frame_length  (out_frame_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Pop side: long hold-off first, else random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop = 1'b0;
      end else begin
        out_pop = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every popped byte
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen.data   = out_byte;
      seen.last   = out_last_byte;
      seen.status = out_status_code;
      seen.len    = out_frame_length;
      sb.check_result(seen);
    end
  end

  function automatic frame_item_t rand_item();
    frame_item_t it;
    it.op    = 1'($urandom_range(1));
    it.chan  = 8'($urandom);
    it.ftype = 8'($urandom);
    it.flags = 16'($urandom);
    it.pkt   = {$urandom, $urandom};
    it.fidx  = 16'($urandom);
    it.fcnt  = 16'($urandom);
    it.ack   = {$urandom, $urandom};
    it.prio  = 8'($urandom);
    it.ts    = {$urandom, $urandom};
    it.plen  = 16'($urandom);
    it.pbyte = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input frame_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_push = 1'b0;
    end
    @(negedge clk);
    in_push           = 1'b1;
    in_op_code        = it.op;
    in_channel_id     = it.chan;
    in_frame_type     = it.ftype;
    in_flag_word      = it.flags;
    in_packet_number  = it.pkt;
    in_frag_pos       = it.fidx;
    in_fragment_count = it.fcnt;
    in_ack_number     = it.ack;
    in_priority_level = it.prio;
    in_time_stamp     = it.ts;
    in_payload_length = it.plen;
    in_payload_byte   = it.pbyte;
    do @(posedge clk); while (in_full);
    sb.note_input(it);
  endtask

  task automatic send_start(input logic [15:0] flags, input logic [15:0] plen, input int fill);
    frame_item_t it;
    it = rand_item();
    if (fill == FILL_ZERO) begin
      {it.chan, it.ftype, it.pkt, it.fidx, it.fcnt, it.ack, it.prio, it.ts} = '0;
    end else if (fill == FILL_ONES) begin
      {it.chan, it.ftype, it.pkt, it.fidx, it.fcnt, it.ack, it.prio, it.ts} = '1;
    end
    it.op    = OP_START;
    it.flags = flags;
    it.plen  = plen;
    send_item(it);
  endtask

  task automatic send_payload(input logic [7:0] b);
    frame_item_t it;
    it = rand_item();
    it.op    = OP_PAYLOAD;
    it.pbyte = b;
    send_item(it);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering and wait until every expected byte has been popped
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, some noise
  task automatic run_random(input int n_items, input bit pause_mid);
    frame_item_t it;
    logic [15:0] plen;
    int          sent;
    int          nbytes;
    int          r;
    sent = 0;
    while (sent < n_items) begin
      if (pause_mid && sent >= n_items / 2) begin
        pause_mid = 1'b0;
        drain();
      end
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(9))
          0:       plen = 16'($urandom);
          1, 2:    plen = 16'($urandom_range(7, 20));
          default: plen = 16'($urandom_range(0, 6));
        endcase
        send_start(16'($urandom), plen, FILL_RAND);
        sent++;
        nbytes = (plen > 16'd20) ? $urandom_range(0, 8) : int'(plen);
        // Occasionally cut the frame short or run past its end
        r = $urandom_range(9);
        if (r == 0 && nbytes > 0) nbytes--;
        else if (r == 1) nbytes++;
        repeat (nbytes) begin
          send_payload(8'($urandom));
          sent++;
        end
      end else begin
        it = rand_item();
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] limit_pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: full-size limit, all field extremes and flag mixes
    write_cfg(CFG_BUFFER_LIMIT, 16'hFFFF);
    write_cfg(CFG_VERSION_BYTE, 16'h00A5);
    send_payload(8'hFF);
    send_start(16'h0000, 16'd0, FILL_ONES);
    send_start(16'hFFFF, 16'd2, FILL_ONES);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_start(16'hFFF0, 16'd0, FILL_ZERO);
    send_start(16'h0001, 16'd1, FILL_RAND);
    send_payload(8'h5A);
    send_start(16'h0002, 16'd0, FILL_RAND);
    send_start(16'h0004, 16'd0, FILL_RAND);
    send_start(16'h0008, 16'd0, FILL_RAND);
    // Abandon an open frame with a new start
    send_start(16'h0000, 16'd3, FILL_RAND);
    send_payload(8'h11);
    send_start(16'h0000, 16'd0, FILL_RAND);
    send_payload(8'h22);
    // Length boundaries around the 16-bit wrap
    send_start(16'h0000, 16'hFFFF, FILL_RAND);
    send_start(16'h0000, 16'd65521, FILL_RAND);
    send_start(16'h000F, 16'd65500, FILL_RAND);
    send_start(16'h000F, 16'd65501, FILL_RAND);
    send_payload(8'h33);
    drain();

    // Directed: tightest limit that still fits a bare header
    write_cfg(CFG_BUFFER_LIMIT, 16'd14);
    write_cfg(CFG_VERSION_BYTE, 16'h0000);
    send_start(16'h0000, 16'd0, FILL_RAND);
    send_start(16'h0000, 16'd1, FILL_RAND);
    send_start(16'h0004, 16'd0, FILL_RAND);
    send_payload(8'h44);
    drain();

    // Directed: zero limit rejects everything
    write_cfg(CFG_BUFFER_LIMIT, 16'h0000);
    write_cfg(CFG_VERSION_BYTE, 16'h00FF);
    send_start(16'h000F, 16'd0, FILL_RAND);
    send_payload(8'h55);
    drain();

    // Random phases under different flow-control mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       limit_pick = 16'hFFFF;
        1:       limit_pick = 16'($urandom_range(14, 60));
        2:       limit_pick = 16'($urandom_range(30, 200));
        default: limit_pick = 16'($urandom);
      endcase
      write_cfg(CFG_BUFFER_LIMIT, limit_pick);
      write_cfg(CFG_VERSION_BYTE, 16'($urandom_range(255)));
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // Hold the pop side so the block fills and pushes back
          hold_cycles    = HOLD_OFF_CYCLES;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      run_random(36, p == 1);
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d bytes never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
